// ===== hw/rtl/tgad_pkg.sv =====
package tgad_pkg;

    // default number of palette entries kept on chip
    localparam int PALETTE_DEPTH_DEF = 256;

    localparam logic [31:0] ALPHA_ON = 32'hFF00_0000;

    // header byte offsets
    localparam logic [4:0] HDR_ID_LEN      = 5'd0;
    localparam logic [4:0] HDR_KIND        = 5'd2;
    localparam logic [4:0] HDR_MAP_LEN_LO  = 5'd5;
    localparam logic [4:0] HDR_MAP_LEN_HI  = 5'd6;
    localparam logic [4:0] HDR_MAP_BITS    = 5'd7;
    localparam logic [4:0] HDR_WIDTH_LO    = 5'd12;
    localparam logic [4:0] HDR_WIDTH_HI    = 5'd13;
    localparam logic [4:0] HDR_HEIGHT_LO   = 5'd14;
    localparam logic [4:0] HDR_HEIGHT_HI   = 5'd15;
    localparam logic [4:0] HDR_PIX_BITS    = 5'd16;
    localparam logic [4:0] HDR_LAST        = 5'd17;

    // image type codes
    localparam logic [7:0] KIND_MAPPED = 8'd1;
    localparam logic [7:0] KIND_TRUE   = 8'd2;
    localparam logic [7:0] KIND_GRAY   = 8'd3;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_ID,
        PH_MAP,
        PH_PIX,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_TYPE  = 2'd1,
        ST_BAD_INDEX = 2'd2
    } status_t;

endpackage

// ===== hw/rtl/tga_stream_pixel_decoder_core.sv =====
// uncompressed tga decoder, one file byte per transfer on the byte channel
// (byte_valid / byte_ready, payload first and byte_in; first marks byte 0 of a
// file and restarts header parsing at any time)
// results leave on the pixel channel (pixel_valid / pixel_ready, payload
// pixel, last, status): one argb word per stored pixel in file order, last on
// the final pixel, or a single status 1 result when the image type is not
// 1, 2 or 3; status 2 flags a palette index outside the loaded map
// the colour map is written into a palette ram of PALETTE_DEPTH words; a
// mapped pixel reads it back, so every result passes one lookup stage and an
// output register, in that order, before it shows on pixel_valid
// throughput is one byte per cycle while byte_ready is high; the palette has a
// single port pair (one write per map entry, one read per pixel, never in the same cycle)
// when the receiver stalls, the lookup stage and the output register hold up
// to two results; byte_ready drops only once both are full
// reset clears all parsing state; palette contents are undefined until the
// map of a file has been loaded, and entries never written are never read
module tga_stream_pixel_decoder_core #(
    parameter int PALETTE_DEPTH = tgad_pkg::PALETTE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_ready,
    input  logic        first,
    input  logic [7:0]  byte_in,
    output logic        pixel_valid,
    input  logic        pixel_ready,
    output logic [31:0] pixel,
    output logic        last,
    output logic [1:0]  status
);

    import tgad_pkg::*;

    localparam int          PAL_AW      = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam logic [32:0] PAL_DEPTH_W = 33'(PALETTE_DEPTH);
    localparam logic [16:0] PAL_DEPTH_E = 17'(PALETTE_DEPTH);

    // bytes per map entry, bit counts above 32 taken as 32
    function automatic logic [2:0] entry_bytes(input logic [7:0] bits);
        logic [5:0] b;
        begin
            b = (bits > 8'd32) ? 6'd32 : bits[5:0];
            return 3'((b + 6'd7) >> 3);
        end
    endfunction

    // pixel depth after the zero and oversize corrections
    function automatic logic [5:0] eff_pix_bits(input logic [7:0] bits);
        begin
            if (bits == 8'd0)
                return 6'd8;
            else if (bits > 8'd32)
                return 6'd32;
            else
                return bits[5:0];
        end
    endfunction

    // parsing state
    phase_t      phase_reg,    phase_next;
    logic [4:0]  hdr_cnt_reg,  hdr_cnt_next;
    logic [7:0]  id_len_reg,   id_len_next;
    logic [7:0]  kind_reg,     kind_next;
    logic [15:0] map_len_reg,  map_len_next;
    logic [7:0]  map_bits_reg, map_bits_next;
    logic [15:0] width_reg,    width_next;
    logic [15:0] height_reg,   height_next;
    logic [7:0]  pix_bits_reg, pix_bits_next;
    logic [7:0]  skip_cnt_reg, skip_cnt_next;
    logic [15:0] entry_cnt_reg, entry_cnt_next;
    logic [1:0]  byte_pos_reg, byte_pos_next;
    logic [31:0] asm_reg,      asm_next;
    logic [31:0] pix_cnt_reg,  pix_cnt_next;
    logic [31:0] total_reg;

    // lookup stage and output register
    logic        s2_valid_reg;
    logic [31:0] s2_pixel_reg;
    logic        s2_last_reg;
    status_t     s2_status_reg;
    logic        s2_pal_reg;
    logic        out_valid_reg;
    logic [31:0] pixel_reg;
    logic        last_reg;
    status_t     status_reg;

    // result of the current byte
    logic        res_valid;
    logic [31:0] res_pixel;
    logic        res_last;
    status_t     res_status;
    logic        res_pal;

    // palette port
    logic              pal_we;
    logic [PAL_AW-1:0] pal_waddr;
    logic [31:0]       pal_wdata;
    logic              pal_re;
    logic [PAL_AW-1:0] pal_raddr;
    logic [31:0]       pal_rdata;

    logic        byte_acc;
    logic        out_load;
    logic        s2_free;
    phase_t      ph;
    logic [4:0]  hc;
    logic [31:0] asm_new;
    logic [2:0]  eb;
    logic [5:0]  pbits;
    logic [2:0]  pb;
    logic [31:0] idx;
    logic [31:0] idx_mask;
    logic [8:0]  skip_inc;
    logic [16:0] entry_inc;
    logic [31:0] pix_inc;
    logic        do_begin_id;
    logic        do_begin_map;
    logic        do_begin_pix;

    assign out_load   = !out_valid_reg || pixel_ready;
    assign s2_free    = !s2_valid_reg || out_load;
    assign byte_ready = s2_free;
    assign byte_acc   = byte_valid && byte_ready;

    assign ph      = first ? PH_HEADER : phase_reg;
    assign hc      = first ? 5'd0 : hdr_cnt_reg;
    assign asm_new = asm_reg | (32'(byte_in) << {byte_pos_reg, 3'b000});
    assign eb      = entry_bytes(map_bits_reg);
    assign pbits   = eff_pix_bits(pix_bits_reg);
    assign pb      = 3'((pbits + 6'd7) >> 3);

    // mapped pixels use only the low bpp bits as the index
    assign idx_mask  = (pbits >= 6'd32) ? 32'hFFFF_FFFF : 32'((33'd1 << pbits) - 33'd1);
    assign idx       = asm_new & idx_mask;
    assign skip_inc  = {1'b0, skip_cnt_reg} + 9'd1;
    assign entry_inc = {1'b0, entry_cnt_reg} + 17'd1;
    assign pix_inc   = pix_cnt_reg + 32'd1;

    assign pal_waddr = entry_cnt_reg[PAL_AW-1:0];
    assign pal_wdata = asm_new;
    assign pal_raddr = idx[PAL_AW-1:0];

    always_comb
    begin
        phase_next     = phase_reg;
        hdr_cnt_next   = hdr_cnt_reg;
        id_len_next    = id_len_reg;
        kind_next      = kind_reg;
        map_len_next   = map_len_reg;
        map_bits_next  = map_bits_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        pix_bits_next  = pix_bits_reg;
        skip_cnt_next  = skip_cnt_reg;
        entry_cnt_next = entry_cnt_reg;
        byte_pos_next  = byte_pos_reg;
        asm_next       = asm_reg;
        pix_cnt_next   = pix_cnt_reg;
        res_valid      = 1'b0;
        res_pixel      = 32'd0;
        res_last       = 1'b0;
        res_status     = ST_OK;
        res_pal        = 1'b0;
        pal_we         = 1'b0;
        pal_re         = 1'b0;
        do_begin_id    = 1'b0;
        do_begin_map   = 1'b0;
        do_begin_pix   = 1'b0;

        if (byte_acc)
        begin
            phase_next   = ph;
            hdr_cnt_next = hc;
            case (ph)
                PH_HEADER:
                begin
                    case (hc)
                        HDR_ID_LEN:     id_len_next   = byte_in;
                        HDR_KIND:       kind_next     = byte_in;
                        HDR_MAP_LEN_LO: map_len_next  = {map_len_reg[15:8], byte_in};
                        HDR_MAP_LEN_HI: map_len_next  = {byte_in, map_len_reg[7:0]};
                        HDR_MAP_BITS:   map_bits_next = byte_in;
                        HDR_WIDTH_LO:   width_next    = {width_reg[15:8], byte_in};
                        HDR_WIDTH_HI:   width_next    = {byte_in, width_reg[7:0]};
                        HDR_HEIGHT_LO:  height_next   = {height_reg[15:8], byte_in};
                        HDR_HEIGHT_HI:  height_next   = {byte_in, height_reg[7:0]};
                        HDR_PIX_BITS:   pix_bits_next = byte_in;
                        default:        ;
                    endcase
                    hdr_cnt_next = hc + 5'd1;
                    if (hc == HDR_LAST)
                    begin
                        hdr_cnt_next = 5'd0;
                        if (kind_reg == KIND_MAPPED || kind_reg == KIND_TRUE ||
                            kind_reg == KIND_GRAY)
                        begin
                            do_begin_id = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_DONE;
                            res_valid  = 1'b1;
                            res_last   = 1'b1;
                            res_status = ST_BAD_TYPE;
                        end
                    end
                end

                PH_ID:
                begin
                    skip_cnt_next = skip_inc[7:0];
                    if (skip_inc >= {1'b0, id_len_reg})
                    begin
                        do_begin_map = 1'b1;
                    end
                end

                PH_MAP:
                begin
                    asm_next = asm_new;
                    if ((3'(byte_pos_reg) + 3'd1) >= eb)
                    begin
                        // entries beyond the store are consumed and dropped
                        pal_we         = ({1'b0, entry_cnt_reg} < PAL_DEPTH_E);
                        entry_cnt_next = entry_inc[15:0];
                        byte_pos_next  = 2'd0;
                        asm_next       = 32'd0;
                        if (entry_inc >= {1'b0, map_len_reg})
                        begin
                            do_begin_pix = 1'b1;
                        end
                    end
                    else
                    begin
                        byte_pos_next = byte_pos_reg + 2'd1;
                    end
                end

                PH_PIX:
                begin
                    asm_next = asm_new;
                    if ((3'(byte_pos_reg) + 3'd1) < pb)
                    begin
                        byte_pos_next = byte_pos_reg + 2'd1;
                    end
                    else
                    begin
                        byte_pos_next = 2'd0;
                        asm_next      = 32'd0;
                        pix_cnt_next  = pix_inc;
                        res_valid     = 1'b1;
                        res_last      = (pix_inc >= total_reg);
                        if (res_last)
                        begin
                            phase_next = PH_DONE;
                        end
                        if (kind_reg == KIND_TRUE)
                        begin
                            res_pixel = (pbits < 6'd32) ? (asm_new | ALPHA_ON) : asm_new;
                        end
                        else if (kind_reg == KIND_GRAY)
                        begin
                            res_pixel = {8'hFF, asm_new[7:0], asm_new[7:0], asm_new[7:0]};
                        end
                        else if (eb == 3'd0 || idx >= {16'd0, map_len_reg} ||
                                 {1'b0, idx} >= PAL_DEPTH_W)
                        begin
                            res_status = ST_BAD_INDEX;
                        end
                        else
                        begin
                            res_pal = 1'b1;
                            pal_re  = 1'b1;
                        end
                    end
                end

                default: ;
            endcase

            // section changes, in file order
            if (do_begin_id)
            begin
                skip_cnt_next = 8'd0;
                if (id_len_reg != 8'd0)
                    phase_next = PH_ID;
                else
                    do_begin_map = 1'b1;
            end
            if (do_begin_map)
            begin
                if (map_len_reg != 16'd0 && eb != 3'd0)
                begin
                    phase_next     = PH_MAP;
                    entry_cnt_next = 16'd0;
                    byte_pos_next  = 2'd0;
                    asm_next       = 32'd0;
                end
                else
                begin
                    do_begin_pix = 1'b1;
                end
            end
            if (do_begin_pix)
            begin
                byte_pos_next = 2'd0;
                asm_next      = 32'd0;
                pix_cnt_next  = 32'd0;
                phase_next    = (width_reg == 16'd0 || height_reg == 16'd0) ? PH_DONE : PH_PIX;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            hdr_cnt_reg   <= 5'd0;
            id_len_reg    <= 8'd0;
            kind_reg      <= 8'd0;
            map_len_reg   <= 16'd0;
            map_bits_reg  <= 8'd0;
            width_reg     <= 16'd0;
            height_reg    <= 16'd0;
            pix_bits_reg  <= 8'd0;
            skip_cnt_reg  <= 8'd0;
            entry_cnt_reg <= 16'd0;
            byte_pos_reg  <= 2'd0;
            asm_reg       <= 32'd0;
            pix_cnt_reg   <= 32'd0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            hdr_cnt_reg   <= hdr_cnt_next;
            id_len_reg    <= id_len_next;
            kind_reg      <= kind_next;
            map_len_reg   <= map_len_next;
            map_bits_reg  <= map_bits_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            pix_bits_reg  <= pix_bits_next;
            skip_cnt_reg  <= skip_cnt_next;
            entry_cnt_reg <= entry_cnt_next;
            byte_pos_reg  <= byte_pos_next;
            asm_reg       <= asm_next;
            pix_cnt_reg   <= pix_cnt_next;
            if (s2_free)
            begin
                s2_valid_reg <= res_valid;
            end
            if (out_load)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // image size; width and height settle at least two bytes before use
    always_ff @(posedge clk)
    begin
        total_reg <= 32'(width_reg) * 32'(height_reg);
    end

    // result payloads, no reset needed
    always_ff @(posedge clk)
    begin
        if (s2_free && res_valid)
        begin
            s2_pixel_reg  <= res_pixel;
            s2_last_reg   <= res_last;
            s2_status_reg <= res_status;
            s2_pal_reg    <= res_pal;
        end
        if (out_load && s2_valid_reg)
        begin
            pixel_reg  <= s2_pal_reg ? (pal_rdata | ALPHA_ON) : s2_pixel_reg;
            last_reg   <= s2_last_reg;
            status_reg <= s2_status_reg;
        end
    end

    tgad_palette_ram #(
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .clk   (clk),
        .we    (pal_we),
        .waddr (pal_waddr),
        .wdata (pal_wdata),
        .re    (pal_re),
        .raddr (pal_raddr),
        .rdata (pal_rdata)
    );

    assign pixel_valid = out_valid_reg;
    assign pixel       = pixel_reg;
    assign last        = last_reg;
    assign status      = status_reg;

endmodule

// ===== hw/rtl/tgad_palette_ram.sv =====
module tgad_palette_ram #(
    parameter int DEPTH = tgad_pkg::PALETTE_DEPTH_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [31:0]   wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [31:0]   rdata
);

    logic [31:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // read data holds until the next read
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
